/* rtl/cba_pkg.sv */
// shared types and constants for the contiguous block allocator
package cba_pkg;
  localparam int NUM_BLOCKS = 128;
  localparam int DIR_ENTRIES = 128;
  localparam int BLK_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int DIR_W = $clog2(DIR_ENTRIES);
  localparam int DCNT_W = $clog2(DIR_ENTRIES + 1);
  localparam int ENT_W = 16 + BLK_W + CNT_W;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE = 1'b1;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_NO_RUN = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_DIR_FULL = 3'd4;

  typedef struct packed {
    logic kind;
    logic [15:0] file_id;
    logic [23:0] file_size;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] start_block;
    logic [7:0] blocks_used;
  } out_word_t;

  typedef struct packed {
    logic [15:0] key;
    logic [BLK_W-1:0] start;
    logic [CNT_W-1:0] nblk;
  } entry_t;
endpackage

/* rtl/cba_ram.sv */
// generic single-port ram with registered read
module cba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* rtl/contiguous_block_allocator.sv */
// contiguous first-fit block allocator, top level
// allocate: 24-step division, free count, map scan, map mark
// free: directory search, directory shift, map release
// one request at a time, results never stall; busy is high from start until the result strobe
// after reset a clearing pass sets every free map entry, busy meanwhile
module contiguous_block_allocator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cba_pkg::in_word_t  in_word,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  output cba_pkg::out_word_t out_word
);
  localparam int BW = cba_pkg::BLK_W;
  localparam int CW = cba_pkg::CNT_W;
  localparam int DW = cba_pkg::DIR_W;
  localparam int DCW = cba_pkg::DCNT_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_CNT, S_SCAN, S_MARK,
    S_SRCH, S_SHIFT_RD, S_SHIFT_WR, S_REL, S_DONE
  } state_t;

  state_t state_r;
  logic [15:0] bsize_r;
  logic [15:0] key_r;
  logic [23:0] quo_r;
  logic [16:0] rem_r;
  logic [4:0]  dstep_r;
  logic [BW:0] ptr_r;
  logic [CW-1:0] nfree_r, run_r;
  logic [BW-1:0] first_r;
  logic [24:0] need_r;
  logic [DCW-1:0] ecount_r;
  logic [DCW:0] dptr_r;
  logic [2:0] st_r;
  logic [BW-1:0] ostart_r;
  logic [CW-1:0] onblk_r;
  logic rd_pend_r;
  cba_pkg::entry_t hold_r;

  logic          fm_we, fm_wd, fm_rd;
  logic [BW-1:0] fm_addr;
  logic          dr_we;
  logic [DW-1:0] dr_addr;
  cba_pkg::entry_t dr_wd, dr_rd;

  cba_ram #(.WIDTH(1), .DEPTH(cba_pkg::NUM_BLOCKS)) u_map (
    .clk(clk), .we(fm_we), .addr(fm_addr), .wdata(fm_wd), .rdata(fm_rd));
  cba_ram #(.WIDTH(cba_pkg::ENT_W), .DEPTH(cba_pkg::DIR_ENTRIES)) u_dir (
    .clk(clk), .we(dr_we), .addr(dr_addr), .wdata(dr_wd), .rdata(dr_rd));

  logic [16:0] trial;
  logic [15:0] bs_eff;
  assign bs_eff = (bsize_r == 16'd0) ? 16'd1 : bsize_r;
  assign trial = {rem_r[15:0], quo_r[23]} - {1'b0, bs_eff};

  always_comb begin
    fm_we = 1'b0;
    fm_wd = 1'b1;
    fm_addr = ptr_r[BW-1:0];
    dr_we = 1'b0;
    dr_addr = dptr_r[DW-1:0];
    dr_wd = dr_rd;
    case (state_r)
      S_CLEAR: fm_we = 1'b1;
      S_MARK: begin
        fm_we = 1'b1;
        fm_wd = 1'b0;
      end
      S_REL: fm_we = 1'b1;
      S_DONE: begin
        if (st_r == cba_pkg::ST_OK && need_r[24]) begin
          dr_we = 1'b1;
          dr_addr = ecount_r[DW-1:0];
          dr_wd = hold_r;
        end
      end
      S_SHIFT_WR: begin
        dr_we = 1'b1;
        dr_addr = dptr_r[DW-1:0] - 1'b1;
        dr_wd = dr_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      bsize_r <= 16'd512;
      ptr_r <= '0;
      ecount_r <= '0;
      out_valid <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) bsize_r <= cfg_wdata;
      case (state_r)
        S_CLEAR: begin
          ptr_r <= ptr_r + 1'b1;
          if (ptr_r == (BW+1)'(cba_pkg::NUM_BLOCKS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            key_r <= in_word.file_id;
            quo_r <= in_word.file_size;
            rem_r <= '0;
            dstep_r <= '0;
            ptr_r <= '0;
            dptr_r <= '0;
            nfree_r <= '0;
            run_r <= '0;
            first_r <= '0;
            rd_pend_r <= 1'b0;
            state_r <= (in_word.kind == cba_pkg::KIND_FREE) ? S_SRCH : S_DIV;
          end
        end
        S_DIV: begin
          if (!trial[16]) begin
            rem_r <= trial;
            quo_r <= {quo_r[22:0], 1'b1};
          end else begin
            rem_r <= {rem_r[15:0], quo_r[23]};
            quo_r <= {quo_r[22:0], 1'b0};
          end
          dstep_r <= dstep_r + 1'b1;
          if (dstep_r == 5'd23) state_r <= S_CNT;
        end
        S_CNT: begin
          // need_r[24] reused as "append entry" flag later
          if (rd_pend_r) nfree_r <= nfree_r + CW'(fm_rd);
          if (ptr_r == (BW+1)'(cba_pkg::NUM_BLOCKS)) begin
            rd_pend_r <= 1'b0;
            ptr_r <= '0;
            need_r <= {1'b0, quo_r} + {24'd0, (rem_r != 17'd0)};
            state_r <= S_SCAN;
          end else begin
            rd_pend_r <= 1'b1;
            ptr_r <= ptr_r + 1'b1;
          end
        end
        S_SCAN: begin
          if (need_r > {{(25-CW){1'b0}}, nfree_r}) begin
            st_r <= cba_pkg::ST_NO_SPACE;
            state_r <= S_DONE;
          end else if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
            if (fm_rd) begin
              if (run_r == '0) first_r <= ptr_r[BW-1:0];
              run_r <= run_r + 1'b1;
              if ({{(25-CW){1'b0}}, run_r + 1'b1} == need_r) begin
                if (ecount_r >= DCW'(cba_pkg::DIR_ENTRIES)) begin
                  st_r <= cba_pkg::ST_DIR_FULL;
                  state_r <= S_DONE;
                end else begin
                  ptr_r <= {1'b0, (run_r == '0) ? ptr_r[BW-1:0] : first_r};
                  state_r <= S_MARK;
                end
              end else if (ptr_r == (BW+1)'(cba_pkg::NUM_BLOCKS - 1)) begin
                st_r <= cba_pkg::ST_NO_RUN;
                state_r <= S_DONE;
              end else ptr_r <= ptr_r + 1'b1;
            end else begin
              run_r <= '0;
              if (ptr_r == (BW+1)'(cba_pkg::NUM_BLOCKS - 1)) begin
                st_r <= cba_pkg::ST_NO_RUN;
                state_r <= S_DONE;
              end else ptr_r <= ptr_r + 1'b1;
            end
          end else rd_pend_r <= 1'b1;
        end
        S_MARK: begin
          ptr_r <= ptr_r + 1'b1;
          if (ptr_r[BW-1:0] - first_r == BW'(run_r - 1'b1)) begin
            st_r <= cba_pkg::ST_OK;
            ostart_r <= first_r;
            onblk_r <= run_r;
            hold_r <= '{key: key_r, start: first_r, nblk: run_r};
            need_r[24] <= 1'b1;
            state_r <= S_DONE;
          end
        end
        S_SRCH: begin
          if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
            if (dr_rd.key == key_r) begin
              ostart_r <= dr_rd.start;
              onblk_r <= dr_rd.nblk;
              ptr_r <= {1'b0, dr_rd.start};
              dptr_r <= dptr_r + 1'b1;
              state_r <= S_SHIFT_RD;
            end else dptr_r <= dptr_r + 1'b1;
          end else if (dptr_r >= {1'b0, ecount_r}) begin
            st_r <= cba_pkg::ST_NOT_FOUND;
            state_r <= S_DONE;
          end else rd_pend_r <= 1'b1;
        end
        S_SHIFT_RD: begin
          if (dptr_r >= {1'b0, ecount_r}) begin
            ecount_r <= ecount_r - 1'b1;
            run_r <= '0;
            state_r <= (onblk_r == '0) ? S_DONE : S_REL;
            st_r <= cba_pkg::ST_OK;
          end else state_r <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          dptr_r <= dptr_r + 1'b1;
          state_r <= S_SHIFT_RD;
        end
        S_REL: begin
          ptr_r <= ptr_r + 1'b1;
          run_r <= run_r + 1'b1;
          if (run_r + 1'b1 == onblk_r ||
              ptr_r == (BW+1)'(cba_pkg::NUM_BLOCKS - 1)) state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_word.status <= st_r;
          out_word.start_block <= (st_r == cba_pkg::ST_OK) ? 7'(ostart_r) : 7'd0;
          out_word.blocks_used <= (st_r == cba_pkg::ST_OK) ? 8'(onblk_r) : 8'd0;
          if (st_r == cba_pkg::ST_OK && need_r[24]) ecount_r <= ecount_r + 1'b1;
          need_r[24] <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ecount_r <= DCW'(cba_pkg::DIR_ENTRIES)) else $error("directory count overflow");
  a_strobe_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DONE)) else $error("stray result strobe");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");
`endif
endmodule
